// ----- rtl/core/mwas_pkg.sv -----
// ----------------------------------------------------------------------------
// mwas_pkg
// Shared types and constants of the max-weight assignment solver.
// ----------------------------------------------------------------------------
package mwas_pkg;

  localparam int unsigned MAX_N_DEF       = 64;
  localparam int unsigned WEIGHT_BITS_DEF = 20;

  localparam int unsigned IDX_BITS      = 6;   // row / column fields
  localparam int unsigned SIZE_BITS     = 7;   // matrix_size register
  localparam int unsigned TOTAL_BITS    = 26;  // running total field
  localparam int unsigned LABEL_BITS    = 32;  // labels and slack
  localparam int unsigned OUT_DATA_BITS = ((2 * IDX_BITS + TOTAL_BITS + 7) / 8) * 8;

  localparam logic [SIZE_BITS-1:0]  SIZE_RESET = SIZE_BITS'(64);
  localparam logic [LABEL_BITS-1:0] SLACK_INF  = LABEL_BITS'(1) << 29;

  // request kinds on tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_SOLVE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_MAX_A, ST_MAX_B, ST_ROUND, ST_CLEAR,
    ST_ROOT_A, ST_ROOT_B, ST_ET_START, ST_ET_LAB, ST_ET_A, ST_ET_B, ST_ET_C,
    ST_BFS_POP, ST_BFS_X, ST_BFS_XL, ST_BFS_A, ST_BFS_B,
    ST_MIN_A, ST_MIN_B, ST_UPD_A, ST_UPD_B, ST_UPD_C, ST_SCAN_A, ST_SCAN_B,
    ST_AUG_A, ST_AUG_B, ST_OUT_A, ST_OUT_B, ST_OUT_C, ST_OUT_W
  } state_e;

  // where tree entry returns to
  typedef enum logic [1:0] {
    RET_ROOT, RET_BFS, RET_SCAN
  } ret_e;

  typedef struct packed {
    logic neg;
    logic zero;
    logic pos;
  } alu_flags_t;

endpackage

// ----- rtl/core/max_weight_assignment_solver_top.sv -----
// ----------------------------------------------------------------------------
// max_weight_assignment_solver_top
// Maximum-weight perfect assignment (Kuhn-Munkres, O(n^3)) over a loaded
// signed weight matrix, iterated on one shared adder under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: tuser = request kind (load / solve), tdata = row, column,
//    weight. A load beat writes one matrix entry; the block is ready again on
//    the next cycle.
//  - A solve beat uses the first matrix_size rows and columns. Every entry in
//    that square must have been loaded before.
//  - Output stream: one beat per row 0..n-1 with its column and the running
//    total of matched weights; tlast marks row n-1.
//  - Solve: the row maxima first, then per matched pair a clear, tree entries,
//    BFS scans and relabel passes. Its run time is set by the single shared
//    a+b-c unit and the label, slack and weight memories with one read port each.
//  - Output: each row goes through ST_OUT_A, ST_OUT_B, ST_OUT_C and ST_OUT_W;
//    a stalled beat holds its data and the block waits, taking no input.
//  - Reset: sequencer idle, matrix_size = 64, no output pending. The weight
//    store is not cleared; all solver state is rebuilt by each solve.
//  - The user writes matrix_size via cfg_we_i while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module max_weight_assignment_solver_top
  import mwas_pkg::*;
#(
  parameter int unsigned MAX_N       = MAX_N_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int unsigned IN_DATA_BITS = ((2 * IDX_BITS + WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config
  input  logic                     cfg_we_i,
  input  logic [SIZE_BITS-1:0]     cfg_wdata_i,
  // input beats
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,  // row_index, col_index, weight
  input  logic                     s_axis_tuser_i,  // req_type
  // result beats
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,  // out_row, out_col, running_total
  output logic                     m_axis_tlast_o   // last
);

  localparam int unsigned IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;  // index bits
  localparam int unsigned MW = $clog2(MAX_N + 1);                // index or none
  localparam int unsigned SW = $clog2(MAX_N + 2);                // path steps
  localparam int unsigned WD = 1 << IW;
  localparam logic [MW-1:0] NONE = MW'(MAX_N);

  // input fields
  logic [IDX_BITS-1:0]    in_row, in_col;
  logic [WEIGHT_BITS-1:0] in_weight;
  assign in_row    = s_axis_tdata_i[IDX_BITS-1:0];
  assign in_col    = s_axis_tdata_i[2*IDX_BITS-1:IDX_BITS];
  assign in_weight = s_axis_tdata_i[2*IDX_BITS +: WEIGHT_BITS];

  // ---------------------------------------------------------------- state
  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic [SIZE_BITS-1:0] size_q;
  logic [MW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, y_q, y_d, x_q, x_d;
  logic [MW-1:0] head_q, head_d, tail_q, tail_d, matched_q, matched_d;
  logic [MW-1:0] et_par_q, et_par_d, c_q, c_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [IW-1:0] et_row_q, et_row_d;
  logic [MAX_N-1:0] rit_q, rit_d, cit_q, cit_d;   // row / column in tree
  logic          out_valid_q, out_valid_d;

  logic signed [LABEL_BITS-1:0] acc_q, acc_d, xlab_q, xlab_d, elab_q, elab_d;
  logic signed [LABEL_BITS-1:0] tmp_q, tmp_d, delta_q, delta_d, d_q, d_d;
  logic [TOTAL_BITS-1:0] total_q, total_d, out_total_q, out_total_d;
  logic [IDX_BITS-1:0]   out_row_q, out_row_d, out_col_q, out_col_d;
  logic                  out_last_q, out_last_d;

  logic [MW-1:0] eff_n;
  logic          s_ready;

  // ------------------------------------------------------------- memories
  logic [WEIGHT_BITS-1:0] w_mem [WD*WD];
  logic                   w_we;
  logic [2*IW-1:0]        w_wa, w_ra;
  logic [WEIGHT_BITS-1:0] w_wd, w_rd_q;

  logic [LABEL_BITS-1:0] rl_mem [MAX_N];
  logic [LABEL_BITS-1:0] cl_mem [MAX_N];
  logic [LABEL_BITS-1:0] sl_mem [MAX_N];
  logic [MW-1:0]         ss_mem [MAX_N];
  logic [MW-1:0]         tp_mem [MAX_N];
  logic [MW-1:0]         rm_mem [MAX_N];
  logic [MW-1:0]         cm_mem [MAX_N];
  logic [IW-1:0]         q_mem  [MAX_N];

  logic rl_we, cl_we, sl_we, ss_we, tp_we, rm_we, cm_we, q_we;
  logic [IW-1:0] rl_wa, cl_wa, sl_wa, ss_wa, tp_wa, rm_wa, cm_wa, q_wa;
  logic [IW-1:0] rl_ra, cl_ra, sl_ra, ss_ra, tp_ra, rm_ra, cm_ra, q_ra;
  logic [LABEL_BITS-1:0] rl_wd, cl_wd, sl_wd, rl_rd_q, cl_rd_q, sl_rd_q;
  logic [MW-1:0] ss_wd, tp_wd, rm_wd, cm_wd, ss_rd_q, tp_rd_q, rm_rd_q, cm_rd_q;
  logic [IW-1:0] q_wd, q_rd_q;

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    w_rd_q <= w_mem[w_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) rl_mem[rl_wa] <= rl_wd;
    if (cl_we) cl_mem[cl_wa] <= cl_wd;
    if (sl_we) sl_mem[sl_wa] <= sl_wd;
    if (ss_we) ss_mem[ss_wa] <= ss_wd;
    if (tp_we) tp_mem[tp_wa] <= tp_wd;
    if (rm_we) rm_mem[rm_wa] <= rm_wd;
    if (cm_we) cm_mem[cm_wa] <= cm_wd;
    if (q_we)  q_mem[q_wa]   <= q_wd;
    rl_rd_q <= rl_mem[rl_ra];
    cl_rd_q <= cl_mem[cl_ra];
    sl_rd_q <= sl_mem[sl_ra];
    ss_rd_q <= ss_mem[ss_ra];
    tp_rd_q <= tp_mem[tp_ra];
    rm_rd_q <= rm_mem[rm_ra];
    cm_rd_q <= cm_mem[cm_ra];
    q_rd_q  <= q_mem[q_ra];
  end

  // ------------------------------------------------------------ shared ALU
  logic signed [LABEL_BITS-1:0] alu_a, alu_b, alu_c;
  logic signed [LABEL_BITS+1:0] alu_res;
  alu_flags_t                   alu_flags;

  mwas_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .c_i     (alu_c),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  logic signed [LABEL_BITS-1:0] w_ext, total_ext;
  assign w_ext     = {{(LABEL_BITS-WEIGHT_BITS){w_rd_q[WEIGHT_BITS-1]}}, w_rd_q};
  assign total_ext = {{(LABEL_BITS-TOTAL_BITS){total_q[TOTAL_BITS-1]}}, total_q};

  // zero acts as 1, above MAX_N acts as MAX_N
  always_comb begin
    if (size_q == '0) begin
      eff_n = MW'(1);
    end else if (size_q > SIZE_BITS'(MAX_N)) begin
      eff_n = NONE;
    end else begin
      eff_n = MW'(size_q);
    end
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;   n_d = n_q;
    i_d = i_q;  j_d = j_q;  y_d = y_q;  x_d = x_q;
    head_d = head_q;  tail_d = tail_q;  matched_d = matched_q;
    et_par_d = et_par_q;  et_row_d = et_row_q;  c_d = c_q;  steps_d = steps_q;
    rit_d = rit_q;  cit_d = cit_q;  out_valid_d = out_valid_q;
    acc_d = acc_q;  xlab_d = xlab_q;  elab_d = elab_q;  tmp_d = tmp_q;
    delta_d = delta_q;  d_d = d_q;  total_d = total_q;
    out_total_d = out_total_q;  out_row_d = out_row_q;
    out_col_d = out_col_q;  out_last_d = out_last_q;
    s_ready = 1'b0;
    alu_a = '0;  alu_b = '0;  alu_c = '0;
    w_we = 1'b0;  w_wa = {in_row[IW-1:0], in_col[IW-1:0]};  w_wd = in_weight;
    w_ra = '0;
    rl_we = 1'b0;  rl_wa = '0;  rl_wd = '0;  rl_ra = '0;
    cl_we = 1'b0;  cl_wa = '0;  cl_wd = '0;  cl_ra = '0;
    sl_we = 1'b0;  sl_wa = '0;  sl_wd = '0;  sl_ra = '0;
    ss_we = 1'b0;  ss_wa = '0;  ss_wd = '0;  ss_ra = '0;
    tp_we = 1'b0;  tp_wa = '0;  tp_wd = '0;  tp_ra = '0;
    rm_we = 1'b0;  rm_wa = '0;  rm_wd = '0;  rm_ra = '0;
    cm_we = 1'b0;  cm_wa = '0;  cm_wd = '0;  cm_ra = '0;
    q_we  = 1'b0;  q_wa  = '0;  q_wd  = '0;  q_ra  = '0;

    case (state_q)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == REQ_LOAD) begin
            w_we = ({1'b0, in_row} < SIZE_BITS'(MAX_N)) &&
                   ({1'b0, in_col} < SIZE_BITS'(MAX_N));
          end else begin
            n_d     = eff_n;
            i_d     = '0;
            state_d = ST_INIT;
          end
        end
      end

      ST_INIT: begin
        if (i_q == n_q) begin
          i_d = '0;  j_d = '0;  acc_d = '0;
          state_d = ST_MAX_A;
        end else begin
          rl_we = 1'b1;  rl_wa = i_q[IW-1:0];  rl_wd = '0;
          cl_we = 1'b1;  cl_wa = i_q[IW-1:0];  cl_wd = '0;
          rm_we = 1'b1;  rm_wa = i_q[IW-1:0];  rm_wd = NONE;
          cm_we = 1'b1;  cm_wa = i_q[IW-1:0];  cm_wd = NONE;
          i_d = i_q + MW'(1);
        end
      end

      // row label = max(0, row maximum)
      ST_MAX_A: begin
        if (i_q == n_q) begin
          matched_d = '0;
          state_d   = ST_ROUND;
        end else if (j_q == n_q) begin
          rl_we = 1'b1;  rl_wa = i_q[IW-1:0];  rl_wd = acc_q;
          i_d = i_q + MW'(1);  j_d = '0;  acc_d = '0;
        end else begin
          w_ra    = {i_q[IW-1:0], j_q[IW-1:0]};
          state_d = ST_MAX_B;
        end
      end

      ST_MAX_B: begin
        alu_a = w_ext;  alu_c = acc_q;
        if (alu_flags.pos) acc_d = w_ext;
        j_d     = j_q + MW'(1);
        state_d = ST_MAX_A;
      end

      ST_ROUND: begin
        if (matched_q == n_q) begin
          i_d = '0;  total_d = '0;
          state_d = ST_OUT_A;
        end else begin
          rit_d = '0;  cit_d = '0;  head_d = '0;  tail_d = '0;  i_d = '0;
          state_d = ST_CLEAR;
        end
      end

      ST_CLEAR: begin
        if (i_q == n_q) begin
          i_d = '0;
          state_d = ST_ROOT_A;
        end else begin
          sl_we = 1'b1;  sl_wa = i_q[IW-1:0];  sl_wd = SLACK_INF;
          ss_we = 1'b1;  ss_wa = i_q[IW-1:0];  ss_wd = NONE;
          tp_we = 1'b1;  tp_wa = i_q[IW-1:0];  tp_wd = NONE;
          i_d = i_q + MW'(1);
        end
      end

      // every free row roots the tree
      ST_ROOT_A: begin
        if (i_q == n_q) begin
          state_d = ST_BFS_POP;
        end else begin
          rm_ra   = i_q[IW-1:0];
          state_d = ST_ROOT_B;
        end
      end

      ST_ROOT_B: begin
        if (rm_rd_q == NONE) begin
          et_row_d = i_q[IW-1:0];  et_par_d = NONE;  ret_d = RET_ROOT;
          state_d  = ST_ET_START;
        end else begin
          i_d     = i_q + MW'(1);
          state_d = ST_ROOT_A;
        end
      end

      // tree entry: mark row, update slack over all columns, enqueue
      ST_ET_START: begin
        rit_d[et_row_q] = 1'b1;
        tp_we = 1'b1;  tp_wa = et_row_q;  tp_wd = et_par_q;
        rl_ra   = et_row_q;
        state_d = ST_ET_LAB;
      end

      ST_ET_LAB: begin
        elab_d  = rl_rd_q;
        j_d     = '0;
        state_d = ST_ET_A;
      end

      ST_ET_A: begin
        if (j_q == n_q) begin
          if (tail_q < NONE) begin
            q_we = 1'b1;  q_wa = tail_q[IW-1:0];  q_wd = et_row_q;
            tail_d = tail_q + MW'(1);
          end
          case (ret_q)
            RET_ROOT: begin
              i_d = i_q + MW'(1);  state_d = ST_ROOT_A;
            end
            RET_BFS: begin
              y_d = y_q + MW'(1);  state_d = ST_BFS_A;
            end
            default: begin
              y_d = y_q + MW'(1);  state_d = ST_SCAN_A;
            end
          endcase
        end else begin
          cl_ra   = j_q[IW-1:0];
          sl_ra   = j_q[IW-1:0];
          w_ra    = {et_row_q, j_q[IW-1:0]};
          state_d = ST_ET_B;
        end
      end

      ST_ET_B: begin
        alu_a = elab_q;  alu_b = cl_rd_q;  alu_c = w_ext;
        d_d     = alu_res[LABEL_BITS-1:0];
        tmp_d   = sl_rd_q;
        state_d = ST_ET_C;
      end

      ST_ET_C: begin
        alu_a = tmp_q;  alu_c = d_q;
        if (alu_flags.pos) begin
          sl_we = 1'b1;  sl_wa = j_q[IW-1:0];  sl_wd = d_q;
          ss_we = 1'b1;  ss_wa = j_q[IW-1:0];  ss_wd = MW'(et_row_q);
        end
        j_d     = j_q + MW'(1);
        state_d = ST_ET_A;
      end

      ST_BFS_POP: begin
        if (head_q < tail_q) begin
          q_ra    = head_q[IW-1:0];
          head_d  = head_q + MW'(1);
          state_d = ST_BFS_X;
        end else begin
          i_d = '0;  delta_d = SLACK_INF;
          state_d = ST_MIN_A;
        end
      end

      ST_BFS_X: begin
        x_d     = MW'(q_rd_q);
        rl_ra   = q_rd_q;
        state_d = ST_BFS_XL;
      end

      ST_BFS_XL: begin
        xlab_d  = rl_rd_q;
        y_d     = '0;
        state_d = ST_BFS_A;
      end

      ST_BFS_A: begin
        if (y_q == n_q) begin
          state_d = ST_BFS_POP;
        end else if (cit_q[y_q[IW-1:0]]) begin
          y_d = y_q + MW'(1);
        end else begin
          cl_ra   = y_q[IW-1:0];
          cm_ra   = y_q[IW-1:0];
          w_ra    = {x_q[IW-1:0], y_q[IW-1:0]};
          state_d = ST_BFS_B;
        end
      end

      // tight edge test: label sum equals weight
      ST_BFS_B: begin
        alu_a = xlab_q;  alu_b = cl_rd_q;  alu_c = w_ext;
        if (!alu_flags.zero) begin
          y_d     = y_q + MW'(1);
          state_d = ST_BFS_A;
        end else if (cm_rd_q == NONE) begin
          matched_d = matched_q + MW'(1);
          steps_d   = '0;
          state_d   = ST_AUG_A;
        end else begin
          cit_d[y_q[IW-1:0]] = 1'b1;
          et_row_d = cm_rd_q[IW-1:0];  et_par_d = x_q;  ret_d = RET_BFS;
          state_d  = ST_ET_START;
        end
      end

      // relabel: delta = min slack outside the tree
      ST_MIN_A: begin
        if (i_q == n_q) begin
          i_d = '0;
          state_d = ST_UPD_A;
        end else if (cit_q[i_q[IW-1:0]]) begin
          i_d = i_q + MW'(1);
        end else begin
          sl_ra   = i_q[IW-1:0];
          state_d = ST_MIN_B;
        end
      end

      ST_MIN_B: begin
        alu_a = sl_rd_q;  alu_c = delta_q;
        if (alu_flags.neg) delta_d = sl_rd_q;
        i_d     = i_q + MW'(1);
        state_d = ST_MIN_A;
      end

      ST_UPD_A: begin
        if (i_q == n_q) begin
          y_d = '0;
          state_d = ST_SCAN_A;
        end else begin
          rl_ra   = i_q[IW-1:0];
          cl_ra   = i_q[IW-1:0];
          sl_ra   = i_q[IW-1:0];
          state_d = ST_UPD_B;
        end
      end

      ST_UPD_B: begin
        tmp_d = cit_q[i_q[IW-1:0]] ? cl_rd_q : sl_rd_q;
        alu_a = rl_rd_q;  alu_c = delta_q;
        if (rit_q[i_q[IW-1:0]]) begin
          rl_we = 1'b1;  rl_wa = i_q[IW-1:0];  rl_wd = alu_res[LABEL_BITS-1:0];
        end
        state_d = ST_UPD_C;
      end

      ST_UPD_C: begin
        if (cit_q[i_q[IW-1:0]]) begin
          alu_a = tmp_q;  alu_b = delta_q;
          cl_we = 1'b1;  cl_wa = i_q[IW-1:0];  cl_wd = alu_res[LABEL_BITS-1:0];
        end else begin
          alu_a = tmp_q;  alu_c = delta_q;
          sl_we = 1'b1;  sl_wa = i_q[IW-1:0];  sl_wd = alu_res[LABEL_BITS-1:0];
        end
        i_d     = i_q + MW'(1);
        state_d = ST_UPD_A;
      end

      // columns that became tight after relabel
      ST_SCAN_A: begin
        if (y_q == n_q) begin
          state_d = ST_BFS_POP;
        end else if (cit_q[y_q[IW-1:0]]) begin
          y_d = y_q + MW'(1);
        end else begin
          sl_ra   = y_q[IW-1:0];
          ss_ra   = y_q[IW-1:0];
          cm_ra   = y_q[IW-1:0];
          state_d = ST_SCAN_B;
        end
      end

      ST_SCAN_B: begin
        if (sl_rd_q != '0) begin
          y_d     = y_q + MW'(1);
          state_d = ST_SCAN_A;
        end else if (cm_rd_q == NONE) begin
          x_d       = ss_rd_q;
          matched_d = matched_q + MW'(1);
          steps_d   = '0;
          state_d   = ST_AUG_A;
        end else begin
          cit_d[y_q[IW-1:0]] = 1'b1;
          if (cm_rd_q < NONE && !rit_q[cm_rd_q[IW-1:0]]) begin
            et_row_d = cm_rd_q[IW-1:0];  et_par_d = ss_rd_q;  ret_d = RET_SCAN;
            state_d  = ST_ET_START;
          end else begin
            y_d     = y_q + MW'(1);
            state_d = ST_SCAN_A;
          end
        end
      end

      // flip the alternating path back to a root
      ST_AUG_A: begin
        if (x_q < NONE && y_q < NONE && steps_q <= SW'(MAX_N)) begin
          rm_ra   = x_q[IW-1:0];
          tp_ra   = x_q[IW-1:0];
          state_d = ST_AUG_B;
        end else begin
          state_d = ST_ROUND;
        end
      end

      ST_AUG_B: begin
        rm_we = 1'b1;  rm_wa = x_q[IW-1:0];  rm_wd = y_q;
        cm_we = 1'b1;  cm_wa = y_q[IW-1:0];  cm_wd = x_q;
        x_d     = tp_rd_q;
        y_d     = rm_rd_q;
        steps_d = steps_q + SW'(1);
        state_d = ST_AUG_A;
      end

      ST_OUT_A: begin
        if (i_q == n_q) begin
          state_d = ST_IDLE;
        end else begin
          rm_ra   = i_q[IW-1:0];
          state_d = ST_OUT_B;
        end
      end

      ST_OUT_B: begin
        c_d     = rm_rd_q;
        w_ra    = {i_q[IW-1:0], rm_rd_q[IW-1:0]};
        state_d = ST_OUT_C;
      end

      ST_OUT_C: begin
        alu_a = total_ext;  alu_b = w_ext;
        if (c_q < NONE) begin
          total_d     = alu_res[TOTAL_BITS-1:0];
          out_total_d = alu_res[TOTAL_BITS-1:0];
        end else begin
          out_total_d = total_q;
        end
        out_row_d   = IDX_BITS'(i_q);
        out_col_d   = IDX_BITS'(c_q);
        out_last_d  = (i_q == n_q - MW'(1));
        out_valid_d = 1'b1;
        state_d     = ST_OUT_W;
      end

      ST_OUT_W: begin
        if (m_axis_tready_i) begin
          out_valid_d = 1'b0;
          i_d         = i_q + MW'(1);
          state_d     = ST_OUT_A;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= RET_ROOT;
      size_q      <= SIZE_RESET;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      y_q         <= '0;
      x_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      matched_q   <= '0;
      steps_q     <= '0;
      rit_q       <= '0;
      cit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      y_q         <= y_d;
      x_q         <= x_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      matched_q   <= matched_d;
      steps_q     <= steps_d;
      rit_q       <= rit_d;
      cit_q       <= cit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working values and output payload
  always_ff @(posedge clk_i) begin
    et_row_q    <= et_row_d;
    et_par_q    <= et_par_d;
    c_q         <= c_d;
    acc_q       <= acc_d;
    xlab_q      <= xlab_d;
    elab_q      <= elab_d;
    tmp_q       <= tmp_d;
    delta_q     <= delta_d;
    d_q         <= d_d;
    total_q     <= total_d;
    out_total_q <= out_total_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_BITS-2*IDX_BITS-TOTAL_BITS){1'b0}},
                            out_total_q, out_col_q, out_row_q};

endmodule

// ----- rtl/core/mwas_alu.sv -----
// ----------------------------------------------------------------------------
// mwas_alu
// Shared a + b - c unit with sign flags, used for the label, slack and total
// arithmetic and most compare operations of the solver.
// ----------------------------------------------------------------------------
module mwas_alu
  import mwas_pkg::*;
(
  input  logic signed [LABEL_BITS-1:0] a_i,
  input  logic signed [LABEL_BITS-1:0] b_i,
  input  logic signed [LABEL_BITS-1:0] c_i,
  output logic signed [LABEL_BITS+1:0] res_o,
  output alu_flags_t                   flags_o
);

  assign res_o = {{2{a_i[LABEL_BITS-1]}}, a_i} + {{2{b_i[LABEL_BITS-1]}}, b_i}
               - {{2{c_i[LABEL_BITS-1]}}, c_i};

  assign flags_o.neg  = res_o[LABEL_BITS+1];
  assign flags_o.zero = (res_o == '0);
  assign flags_o.pos  = !res_o[LABEL_BITS+1] && (res_o != '0);

endmodule

// ----- rtl/core/mwas_chk.sv -----
// ----------------------------------------------------------------------------
// mwas_chk
// Port-level checks of the solver's stream behavior, bound to the top level.
// ----------------------------------------------------------------------------
module mwas_chk
  import mwas_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid_i,
  input logic                     s_axis_tready_o,
  input logic                     s_axis_tuser_i,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,
  input logic                     m_axis_tlast_o
);

  // one item at a time: no input taken while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result pending");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

  // a load returns straight to ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == REQ_LOAD) |=>
      s_axis_tready_o)
    else $error("load did not return to ready");

  // more rows follow a beat without tlast
  a_more_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> !s_axis_tready_o)
    else $error("block idle before last row");

  // the final row ends the burst
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("result after last row");

endmodule

bind max_weight_assignment_solver_top mwas_chk u_mwas_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
